>>> rtl/bvie_pkg.sv
// ----------------------------------------------------------------------------
// Byte variable instruction executor package
// Operation codes, status codes and the request and response types of the
// shared arithmetic unit.
// ----------------------------------------------------------------------------
package bvie_pkg;

    typedef enum logic [4:0] {
        OP_ASSIGN  = 5'd0,
        OP_MOVE    = 5'd1,
        OP_ADD     = 5'd2,
        OP_SUB     = 5'd3,
        OP_MUL     = 5'd4,
        OP_DIV     = 5'd5,
        OP_INCR    = 5'd6,
        OP_DECR    = 5'd7,
        OP_INV     = 5'd8,
        OP_TOB     = 5'd9,
        OP_CMP     = 5'd10,
        OP_HIGH    = 5'd11,
        OP_LOW     = 5'd12,
        OP_LABEL   = 5'd13,
        OP_JUMP    = 5'd14,
        OP_CMPJUMP = 5'd15,
        OP_RET     = 5'd16,
        OP_DEBUG   = 5'd17,
        OP_ERROR   = 5'd18,
        OP_SINT    = 5'd19,
        OP_INT     = 5'd20,
        OP_EXIT    = 5'd21,
        OP_INVALID = 5'd22
    } t_opcode;

    localparam logic [1:0] ST_CONTINUE   = 2'd0;
    localparam logic [1:0] ST_EXIT       = 2'd1;
    localparam logic [1:0] ST_INVALID    = 2'd2;
    localparam logic [1:0] ST_USER_ERROR = 2'd3;

    localparam logic [7:0] INVALID_CODE = 8'hB1;

    typedef struct packed {
        logic       start;
        logic [4:0] op;
        logic [7:0] x;
        logic [7:0] y;
    } t_alu_req;

    typedef struct packed {
        logic       done;
        logic [7:0] result;
    } t_alu_rsp;

endpackage

>>> rtl/byte_variable_instruction_executor.sv
// ----------------------------------------------------------------------------
// Byte variable instruction executor
// Executes one decoded bytecode instruction per input word against a file of
// byte variables, a label table, a return position and a user-function id.
// ----------------------------------------------------------------------------
// One input word is taken only while the sequencer is idle, and produces
// exactly one output word. Division takes longer than other instructions,
// because the shared arithmetic unit resolves one quotient bit per cycle.
// The three possible variable reads go through the single read port of the
// variable RAM, one per cycle. A new word can be accepted while the previous
// result still waits at the output; the block stalls in its write-back step
// only when that output is still full.
// After reset both stores are cleared to zero by a pass that writes one entry
// of each per cycle. The pass walks the larger of NUM_VARIABLES and
// NUM_LABELS entries, and the input is not ready until it has finished.
module byte_variable_instruction_executor #(
    parameter int NUM_VARIABLES = 256,
    parameter int NUM_LABELS    = 256,
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [4:0]  i_operation,
    input  logic        i_first_is_var,
    input  logic [7:0]  i_first_operand,
    input  logic        i_second_is_var,
    input  logic [7:0]  i_second_operand,
    input  logic        i_third_is_var,
    input  logic [7:0]  i_third_operand,
    input  logic [15:0] i_next_position,
    input  logic        i_scan_pass,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_jump_taken,
    output logic [15:0] o_target_position,
    output logic [1:0]  o_status,
    output logic [7:0]  o_error_code,
    output logic        o_debug_valid,
    output logic [7:0]  o_debug_value,
    output logic        o_call_valid,
    output logic [7:0]  o_call_id
);

    localparam int VAR_AW = $clog2(NUM_VARIABLES);
    localparam int LBL_AW = $clog2(NUM_LABELS);
    localparam logic [8:0] VAR_LIMIT = 9'(NUM_VARIABLES);
    localparam logic [8:0] LBL_LIMIT = 9'(NUM_LABELS);
    localparam int CLR_DEPTH = (NUM_VARIABLES > NUM_LABELS) ? NUM_VARIABLES : NUM_LABELS;
    localparam logic [8:0] CLR_LAST = 9'(CLR_DEPTH - 1);

    // Sequencer: CLEAR zeroes both stores after reset, IDLE presents the
    // first operand address, RD2 and RD3 read the second and third, EXE
    // starts the arithmetic unit, ALUW waits for it, and WB commits state and
    // loads the output word.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD2   = 7'b0000010,
        S_RD3   = 7'b0000100,
        S_EXE   = 7'b0001000,
        S_ALUW  = 7'b0010000,
        S_WB    = 7'b0100000,
        S_CLEAR = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Latched instruction word.
    logic [4:0]               r_op;
    logic                     r_fiv, r_siv, r_tiv, r_scan;
    logic [7:0]               r_f, r_s, r_t;
    logic [POSITION_BITS-1:0] r_next;

    // Raw variable contents at the three operand indexes.
    logic [7:0] r_vf, r_vs, r_vt;

    logic [POSITION_BITS-1:0] r_ret;
    logic [7:0]               r_uid;
    logic [8:0]               r_clr_addr;

    // Output register.
    logic        r_out_valid;
    logic        r_jump;
    logic [15:0] r_target;
    logic [1:0]  r_status;
    logic [7:0]  r_err;
    logic        r_dbg_v;
    logic [7:0]  r_dbg_d;
    logic        r_call_v;
    logic [7:0]  r_call_d;

    logic [VAR_AW-1:0]        var_raddr;
    logic [7:0]               var_rdata;
    logic                     var_we;
    logic [7:0]               var_dest;
    logic [7:0]               var_wdata;
    logic                     var_wr;
    logic [POSITION_BITS-1:0] lbl_rdata;
    logic                     lbl_we;
    logic                     ret_we;
    logic                     uid_we;

    logic                     clearing;
    logic                     var_ram_we;
    logic [VAR_AW-1:0]        var_ram_waddr;
    logic [7:0]               var_ram_wdata;
    logic                     lbl_ram_we;
    logic [LBL_AW-1:0]        lbl_ram_waddr;
    logic [POSITION_BITS-1:0] lbl_ram_wdata;

    logic                     f_hit, s_hit, t_hit;
    logic [7:0]               opa, opb, opc, lbl_idx;
    logic                     lbl_hit;
    logic [POSITION_BITS-1:0] lbl_val;
    logic                     out_free, commit, accept;
    logic                     is_unary;

    bvie_pkg::t_alu_req alu_req;
    bvie_pkg::t_alu_rsp alu_rsp;

    logic        n_jump;
    logic [15:0] n_target;
    logic [1:0]  n_status;
    logic [7:0]  n_err;
    logic        n_dbg_v;
    logic [7:0]  n_dbg_d;
    logic        n_call_v;
    logic [7:0]  n_call_d;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign commit     = (r_state == S_WB) && out_free;
    assign clearing   = (r_state == S_CLEAR);

    // A variable read hits only for an index inside the file; an index
    // beyond it reads as zero.
    assign f_hit = ({1'b0, r_f} < VAR_LIMIT);
    assign s_hit = ({1'b0, r_s} < VAR_LIMIT);
    assign t_hit = ({1'b0, r_t} < VAR_LIMIT);

    assign opa = r_fiv ? r_vf : r_f;
    assign opb = r_siv ? r_vs : r_s;
    assign opc = r_tiv ? r_vt : r_t;

    // The jump label comes from the first operand, the compare-jump label from
    // the third. Both are settled after EXE, so the label RAM read address is
    // stable well before write-back uses its data.
    assign lbl_idx = (r_op == bvie_pkg::OP_JUMP) ? opa : opc;
    assign lbl_hit = ({1'b0, lbl_idx} < LBL_LIMIT);
    assign lbl_val = lbl_hit ? lbl_rdata : '0;

    always_comb begin
        case (r_state)
            S_IDLE:  var_raddr = i_first_operand[VAR_AW-1:0];
            S_RD2:   var_raddr = r_s[VAR_AW-1:0];
            default: var_raddr = r_t[VAR_AW-1:0];
        endcase
    end

    // During the clearing pass the write ports walk both stores with zeros.
    assign var_ram_we    = clearing ? (r_clr_addr < VAR_LIMIT) : var_we;
    assign var_ram_waddr = clearing ? r_clr_addr[VAR_AW-1:0] : var_dest[VAR_AW-1:0];
    assign var_ram_wdata = clearing ? 8'd0 : var_wdata;
    assign lbl_ram_we    = clearing ? (r_clr_addr < LBL_LIMIT) : lbl_we;
    assign lbl_ram_waddr = clearing ? r_clr_addr[LBL_AW-1:0] : r_f[LBL_AW-1:0];
    assign lbl_ram_wdata = clearing ? '0 : r_next;

    bvie_ram #(
        .WIDTH (8),
        .DEPTH (NUM_VARIABLES)
    ) u_var_ram (
        .i_clk   (i_clk),
        .i_we    (var_ram_we),
        .i_waddr (var_ram_waddr),
        .i_wdata (var_ram_wdata),
        .i_raddr (var_raddr),
        .o_rdata (var_rdata)
    );

    bvie_ram #(
        .WIDTH (POSITION_BITS),
        .DEPTH (NUM_LABELS)
    ) u_lbl_ram (
        .i_clk   (i_clk),
        .i_we    (lbl_ram_we),
        .i_waddr (lbl_ram_waddr),
        .i_wdata (lbl_ram_wdata),
        .i_raddr (lbl_idx[LBL_AW-1:0]),
        .o_rdata (lbl_rdata)
    );

    // Unary updates work on the variable itself, whatever the operand flag.
    assign is_unary = (r_op == bvie_pkg::OP_INCR) || (r_op == bvie_pkg::OP_DECR) ||
                      (r_op == bvie_pkg::OP_INV)  || (r_op == bvie_pkg::OP_TOB);

    assign alu_req.start = (r_state == S_EXE);
    assign alu_req.op    = r_op;
    assign alu_req.x     = is_unary ? r_vf : opa;
    assign alu_req.y     = opb;

    bvie_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    // Result and state updates of the instruction in write-back. Label, error,
    // exit and undefined codes act in both passes; everything else only when
    // executing.
    always_comb begin
        n_jump    = 1'b0;
        n_target  = 16'd0;
        n_status  = bvie_pkg::ST_CONTINUE;
        n_err     = 8'd0;
        n_dbg_v   = 1'b0;
        n_dbg_d   = 8'd0;
        n_call_v  = 1'b0;
        n_call_d  = 8'd0;
        var_wr    = 1'b0;
        var_wdata = alu_rsp.result;
        lbl_we    = 1'b0;
        ret_we    = 1'b0;
        uid_we    = 1'b0;
        var_dest  = r_t;
        if ((r_op == bvie_pkg::OP_ASSIGN) || (r_op == bvie_pkg::OP_MOVE) || is_unary) begin
            var_dest = r_f;
        end
        if (r_op == bvie_pkg::OP_LABEL) begin
            lbl_we = commit && ({1'b0, r_f} < LBL_LIMIT);
        end else if (r_op == bvie_pkg::OP_ERROR) begin
            n_status = bvie_pkg::ST_USER_ERROR;
            n_err    = r_scan ? 8'd0 : opa;
        end else if (r_op == bvie_pkg::OP_EXIT) begin
            n_status = bvie_pkg::ST_EXIT;
        end else if (r_op >= bvie_pkg::OP_INVALID) begin
            n_status = bvie_pkg::ST_INVALID;
            n_err    = bvie_pkg::INVALID_CODE;
        end else if (!r_scan) begin
            case (r_op)
                bvie_pkg::OP_ASSIGN: begin
                    var_wr    = 1'b1;
                    var_wdata = r_s;
                end
                bvie_pkg::OP_MOVE: begin
                    var_wr    = 1'b1;
                    var_wdata = r_vs;
                end
                bvie_pkg::OP_ADD, bvie_pkg::OP_SUB, bvie_pkg::OP_MUL, bvie_pkg::OP_DIV,
                bvie_pkg::OP_INCR, bvie_pkg::OP_DECR, bvie_pkg::OP_INV, bvie_pkg::OP_TOB,
                bvie_pkg::OP_CMP, bvie_pkg::OP_HIGH, bvie_pkg::OP_LOW: begin
                    var_wr = 1'b1;
                end
                bvie_pkg::OP_JUMP: begin
                    ret_we   = commit;
                    n_jump   = 1'b1;
                    n_target = 16'(lbl_val);
                end
                bvie_pkg::OP_CMPJUMP: begin
                    if (opa == opb) begin
                        n_jump   = 1'b1;
                        n_target = 16'(lbl_val);
                    end
                end
                bvie_pkg::OP_RET: begin
                    n_jump   = 1'b1;
                    n_target = 16'(r_ret);
                end
                bvie_pkg::OP_DEBUG: begin
                    n_dbg_v = 1'b1;
                    n_dbg_d = opa;
                end
                bvie_pkg::OP_SINT: begin
                    uid_we = commit;
                end
                bvie_pkg::OP_INT: begin
                    n_call_v = 1'b1;
                    n_call_d = r_uid;
                end
                default: begin
                end
            endcase
        end
    end

    // Writes to an index beyond the file are dropped.
    assign var_we = commit && var_wr && ({1'b0, var_dest} < VAR_LIMIT);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RD2;
                end
            end
            S_RD2:  n_state = S_RD3;
            S_RD3:  n_state = S_EXE;
            S_EXE:  n_state = S_ALUW;
            S_ALUW: begin
                if (alu_rsp.done) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_clr_addr  <= 9'd0;
            r_ret       <= '0;
            r_uid       <= 8'd0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (clearing) begin
                r_clr_addr <= r_clr_addr + 9'd1;
            end
            if (ret_we) begin
                r_ret <= r_next;
            end
            if (uid_we) begin
                r_uid <= opa;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_operation;
            r_fiv  <= i_first_is_var;
            r_f    <= i_first_operand;
            r_siv  <= i_second_is_var;
            r_s    <= i_second_operand;
            r_tiv  <= i_third_is_var;
            r_t    <= i_third_operand;
            r_next <= POSITION_BITS'(i_next_position);
            r_scan <= i_scan_pass;
        end
        if (r_state == S_RD2) begin
            r_vf <= f_hit ? var_rdata : 8'd0;
        end
        if (r_state == S_RD3) begin
            r_vs <= s_hit ? var_rdata : 8'd0;
        end
        if (r_state == S_EXE) begin
            r_vt <= t_hit ? var_rdata : 8'd0;
        end
        if (commit) begin
            r_jump   <= n_jump;
            r_target <= n_target;
            r_status <= n_status;
            r_err    <= n_err;
            r_dbg_v  <= n_dbg_v;
            r_dbg_d  <= n_dbg_d;
            r_call_v <= n_call_v;
            r_call_d <= n_call_d;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_jump_taken      = r_jump;
    assign o_target_position = r_target;
    assign o_status          = r_status;
    assign o_error_code      = r_err;
    assign o_debug_valid     = r_dbg_v;
    assign o_debug_value     = r_dbg_d;
    assign o_call_valid      = r_call_v;
    assign o_call_id         = r_call_d;

    // An accepted word always starts the operand reads.
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_RD2))
        else $error("accepted word did not start the operand reads");

    // The scan pass never touches the variable file.
    a_scan_no_var_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        var_we |-> !r_scan)
        else $error("variable written during the scan pass");

    // The arithmetic unit reports completion only while the sequencer waits.
    a_alu_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == S_ALUW))
        else $error("arithmetic unit finished outside its wait step");

    // A taken jump never carries an exit or error status.
    a_jump_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_jump_taken) |-> (o_status == bvie_pkg::ST_CONTINUE))
        else $error("jump reported together with a stop status");

    // Debug and user call are separate instructions.
    a_debug_call_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_debug_valid && o_call_valid))
        else $error("debug and call both flagged in one word");

endmodule

>>> rtl/bvie_ram.sv
// ----------------------------------------------------------------------------
// Generic single port pair RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bvie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bvie_alu.sv
// ----------------------------------------------------------------------------
// Shared byte arithmetic unit
// Add, subtract, multiply, compare and unary updates finish in the cycle after
// start; division runs a restoring shift-subtract loop, one bit per cycle.
// ----------------------------------------------------------------------------
module bvie_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bvie_pkg::t_alu_req i_req,
    output bvie_pkg::t_alu_rsp o_rsp
);

    logic       r_busy, n_busy;
    logic       r_done, n_done;
    logic [2:0] r_cnt, n_cnt;
    logic [7:0] r_rem, n_rem;
    logic [7:0] r_quo, n_quo;
    logic [7:0] r_dvs, n_dvs;
    logic [7:0] r_result, n_result;
    logic [8:0] rem_sh;
    logic [8:0] rem_sub;
    logic [15:0] product;

    always_comb begin
        product  = {8'd0, i_req.x} * {8'd0, i_req.y};
        rem_sh   = {r_rem, r_quo[7]};
        rem_sub  = rem_sh - {1'b0, r_dvs};
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_dvs    = r_dvs;
        n_result = r_result;
        if (r_busy) begin
            // A clear sign bit means the shifted remainder covered the divisor.
            if (!rem_sub[8]) begin
                n_rem = rem_sub[7:0];
                n_quo = {r_quo[6:0], 1'b1};
            end else begin
                n_rem = rem_sh[7:0];
                n_quo = {r_quo[6:0], 1'b0};
            end
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy   = 1'b0;
                n_done   = 1'b1;
                n_result = n_quo;
            end
        end else if (i_req.start) begin
            n_done = 1'b1;
            case (i_req.op)
                bvie_pkg::OP_ADD:  n_result = i_req.x + i_req.y;
                bvie_pkg::OP_SUB:  n_result = i_req.x - i_req.y;
                bvie_pkg::OP_MUL:  n_result = product[7:0];
                bvie_pkg::OP_INCR: n_result = i_req.x + 8'd1;
                bvie_pkg::OP_DECR: n_result = i_req.x - 8'd1;
                bvie_pkg::OP_INV:  n_result = {7'd0, i_req.x == 8'd0};
                bvie_pkg::OP_TOB:  n_result = {7'd0, i_req.x != 8'd0};
                bvie_pkg::OP_CMP:  n_result = {7'd0, i_req.x == i_req.y};
                bvie_pkg::OP_HIGH: n_result = {7'd0, i_req.x > i_req.y};
                bvie_pkg::OP_LOW:  n_result = {7'd0, i_req.x < i_req.y};
                bvie_pkg::OP_DIV: begin
                    if (i_req.y == 8'd0) begin
                        n_result = 8'hFF;
                    end else begin
                        n_done = 1'b0;
                        n_busy = 1'b1;
                        n_cnt  = 3'd0;
                        n_rem  = 8'd0;
                        n_quo  = i_req.x;
                        n_dvs  = i_req.y;
                    end
                end
                default: n_result = 8'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt    <= n_cnt;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_dvs    <= n_dvs;
        r_result <= n_result;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule
